>>> design/bclv_pkg.sv
// ----------------------------------------------------------------------------
// bclv_pkg
// Shared widths, codes and elaboration-time tables for the day-curve light
// level pipeline.
// ----------------------------------------------------------------------------
package bclv_pkg;

	localparam int XW        = 17;  // seconds since midnight
	localparam int TW        = 17;  // distance from midpoint, doubled
	localparam int DENW      = 34;  // squared window length
	localparam int NW        = 51;  // divider numerator and remainder
	localparam int QW        = 17;  // squared position, Q16, at most 1.0
	localparam int LW        = 19;  // log2 ratio, Q16
	localparam int FRAC      = 16;
	localparam int RW        = 31;  // 2^-e, Q30
	localparam int CW        = 30;
	localparam int PW        = 7;
	localparam int LVLW      = 10;
	localparam int EXP_BITS  = 8;   // fraction bits of the exponent that are used

	localparam logic [RW-1:0]   ONE_Q30   = RW'(64'd1 << 30);
	localparam logic [16:0]     LVL_SCALE = 17'd1023;
	localparam logic [17:0]     RECIP_100 = 18'd167773; // ceil(2^24 / 100)
	localparam logic [LVLW-1:0] LVL_MAX   = 10'd1023;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_PEAK  = 2'd2;
	localparam logic [1:0] REG_EDGE  = 2'd3;

	// How an item is finished.
	localparam logic [1:0] MODE_CURVE = 2'd0;
	localparam logic [1:0] MODE_ZERO  = 2'd1;
	localparam logic [1:0] MODE_FLAT  = 2'd2;

	typedef struct packed {
		logic [1:0]    mode;
		logic [LW-1:0] lgr;
	} meta_t;

	typedef logic [LW-1:0] log2_tab_t [128];
	typedef logic [CW-1:0] root_tab_t [EXP_BITS];

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bitv;
		v    = val;
		res  = 64'd0;
		bitv = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (bitv > v) begin
				bitv = bitv >> 2;
			end
		end
		for (int j = 0; j < 32; j++) begin
			if (bitv != 64'd0) begin
				if (v >= res + bitv) begin
					v   = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// log2 in Q16 by repeated squaring of a Q30 mantissa.
	function automatic logic [LW-1:0] log2q(input logic [63:0] n);
		logic [63:0] k;
		logic [63:0] m;
		logic [63:0] acc;
		k = 64'd0;
		for (int j = 0; j < 6; j++) begin
			if (k < 64'd6 && (n >> (k + 64'd1)) != 64'd0) begin
				k = k + 64'd1;
			end
		end
		m   = n << (64'd30 - k);
		acc = k << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				acc = acc | (64'd1 << i);
				m   = m >> 1;
			end
		end
		return LW'(acc);
	endfunction

	function automatic log2_tab_t build_log2_tab();
		log2_tab_t tab;
		for (int n = 0; n < 128; n++) begin
			tab[n] = log2q(64'(n));
		end
		return tab;
	endfunction

	// Entry i holds 2^(-2^-(i+1)) in Q30.
	function automatic root_tab_t build_root_tab();
		root_tab_t   tab;
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int i = 0; i < EXP_BITS; i++) begin
			tab[i] = CW'(c);
			c = isqrt64(c << 30);
		end
		return tab;
	endfunction

	localparam log2_tab_t LOG2_TAB = build_log2_tab();
	localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

>>> design/bclv_in_if.sv
// ----------------------------------------------------------------------------
// bclv_in_if
// Time-of-day channel: valid, ready and the hour, minute and second fields.
// ----------------------------------------------------------------------------
interface bclv_in_if;
	logic       valid;
	logic       ready;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;

	modport source (output valid, hour, minute, second, input ready);
	modport sink (input valid, hour, minute, second, output ready);
endinterface

>>> design/bclv_out_if.sv
// ----------------------------------------------------------------------------
// bclv_out_if
// Light level channel: valid, ready and the 10-bit drive level.
// ----------------------------------------------------------------------------
interface bclv_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] light_level;

	modport source (output valid, light_level, input ready);
	modport sink (input valid, light_level, output ready);
endinterface

>>> design/bclv_div.sv
// ----------------------------------------------------------------------------
// bclv_div
// Pipelined restoring divider, one quotient bit per stage, for the squared
// position within the window.
// ----------------------------------------------------------------------------
module bclv_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  logic [bclv_pkg::NW-1:0]    num,
	input  logic [bclv_pkg::DENW-1:0]  den,
	input  bclv_pkg::meta_t            up_meta,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output logic [bclv_pkg::QW-1:0]    quot,
	output bclv_pkg::meta_t            dn_meta
);

	localparam int NS = bclv_pkg::QW;

	logic [NS-1:0]               vld_s;
	logic [NS-1:0]               en;
	logic [bclv_pkg::NW-1:0]     rem_s [NS];
	logic [bclv_pkg::QW-1:0]     q_s [NS];
	logic [bclv_pkg::DENW-1:0]   den_s [NS];
	bclv_pkg::meta_t             meta_s [NS];

	logic [bclv_pkg::NW-1:0]     rem_nx [NS];
	logic [bclv_pkg::QW-1:0]     q_nx [NS];

	always_comb begin
		en[NS-1] = !vld_s[NS-1] || dn_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	// Stage k decides quotient bit NS-1-k.
	always_comb begin
		logic [bclv_pkg::NW-1:0]   r_in;
		logic [bclv_pkg::QW-1:0]   q_in;
		logic [bclv_pkg::DENW-1:0] d_in;
		logic [bclv_pkg::NW-1:0]   dsh;
		for (int k = 0; k < NS; k++) begin
			r_in = (k == 0) ? num : rem_s[(k == 0) ? 0 : k - 1];
			q_in = (k == 0) ? '0 : q_s[(k == 0) ? 0 : k - 1];
			d_in = (k == 0) ? den : den_s[(k == 0) ? 0 : k - 1];
			dsh  = bclv_pkg::NW'(d_in) << (NS - 1 - k);
			if (r_in >= dsh) begin
				rem_nx[k] = r_in - dsh;
				q_nx[k]   = q_in | (bclv_pkg::QW'(1) << (NS - 1 - k));
			end else begin
				rem_nx[k] = r_in;
				q_nx[k]   = q_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= (k == 0) ? up_valid : vld_s[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (en[k]) begin
				rem_s[k]  <= rem_nx[k];
				q_s[k]    <= q_nx[k];
				den_s[k]  <= (k == 0) ? den : den_s[(k == 0) ? 0 : k - 1];
				meta_s[k] <= (k == 0) ? up_meta : meta_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign up_ready = en[0];
	assign dn_valid = vld_s[NS-1];
	assign quot     = q_s[NS-1];
	assign dn_meta  = meta_s[NS-1];

endmodule

>>> design/bclv_exp.sv
// ----------------------------------------------------------------------------
// bclv_exp
// Exponent product and 2^-e evaluation: one root-table multiply per stage,
// then the shift by the integer part (or 1.0 for flat and 0 for zero mode).
// ----------------------------------------------------------------------------
module bclv_exp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  logic [bclv_pkg::QW-1:0] u2,
	input  bclv_pkg::meta_t         up_meta,
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output logic [bclv_pkg::RW-1:0] pow
);

	localparam int NS = bclv_pkg::EXP_BITS + 2;
	localparam int PRW = bclv_pkg::QW + bclv_pkg::LW;
	localparam int MW = bclv_pkg::RW + bclv_pkg::CW;

	logic [NS-1:0]                 vld_s;
	logic [NS-1:0]                 en;
	logic [bclv_pkg::LW-1:0]       ex_s [NS];
	logic [bclv_pkg::RW-1:0]       r_s [NS];
	logic [1:0]                    mode_s [NS];

	logic [PRW-1:0]                ex_prod;
	logic [bclv_pkg::RW-1:0]       r_nx [NS];

	always_comb begin
		en[NS-1] = !vld_s[NS-1] || dn_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign ex_prod = PRW'(u2) * PRW'(up_meta.lgr);

	always_comb begin
		logic [MW-1:0] prod;
		logic [2:0]    ipart;
		r_nx[0] = bclv_pkg::ONE_Q30;
		for (int i = 1; i <= bclv_pkg::EXP_BITS; i++) begin
			prod = MW'(r_s[i-1]) * MW'(bclv_pkg::ROOT_TAB[i-1]);
			if (ex_s[i-1][bclv_pkg::FRAC - i]) begin
				r_nx[i] = prod[MW-1:30];
			end else begin
				r_nx[i] = r_s[i-1];
			end
		end
		ipart = ex_s[NS-2][bclv_pkg::LW-1:bclv_pkg::FRAC];
		case (mode_s[NS-2])
			bclv_pkg::MODE_FLAT:  r_nx[NS-1] = bclv_pkg::ONE_Q30;
			bclv_pkg::MODE_CURVE: r_nx[NS-1] = r_s[NS-2] >> ipart;
			default:              r_nx[NS-1] = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= (k == 0) ? up_valid : vld_s[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (en[k]) begin
				r_s[k] <= r_nx[k];
				if (k == 0) begin
					ex_s[k]   <= ex_prod[bclv_pkg::FRAC +: bclv_pkg::LW];
					mode_s[k] <= up_meta.mode;
				end else begin
					ex_s[k]   <= ex_s[(k == 0) ? 0 : k - 1];
					mode_s[k] <= mode_s[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	assign up_ready = en[0];
	assign dn_valid = vld_s[NS-1];
	assign pow      = r_s[NS-1];

endmodule

>>> design/bclv_scale.sv
// ----------------------------------------------------------------------------
// bclv_scale
// Scales 2^-e by the peak percent to the 10-bit drive level, with the
// divide by 100 done as a reciprocal multiply.
// ----------------------------------------------------------------------------
module bclv_scale (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  logic [bclv_pkg::RW-1:0]   pow,
	input  logic [bclv_pkg::PW-1:0]   peak,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output logic [bclv_pkg::LVLW-1:0] level
);

	localparam int SW = 17;
	localparam int PRW = SW + bclv_pkg::RW;
	localparam int QPW = SW + 18;

	logic          vld_s1;
	logic          vld_s2;
	logic          en1;
	logic          en2;
	logic [SW-1:0] mk;
	logic [PRW-1:0] prod;
	logic [SW-1:0] v_s1;
	logic [QPW-1:0] qprod;
	logic [10:0]   q;
	logic [bclv_pkg::LVLW-1:0] lvl_s2;

	assign en2 = !vld_s2 || dn_ready;
	assign en1 = !vld_s1 || en2;

	assign mk    = SW'(peak) * bclv_pkg::LVL_SCALE;
	assign prod  = PRW'(mk) * PRW'(pow);
	assign qprod = QPW'(v_s1) * QPW'(bclv_pkg::RECIP_100);
	assign q     = qprod[34:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= up_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			v_s1 <= prod[30 +: SW];
		end
		if (en2) begin
			lvl_s2 <= (q > 11'(bclv_pkg::LVL_MAX)) ? bclv_pkg::LVL_MAX : q[9:0];
		end
	end

	assign up_ready = en1;
	assign dn_valid = vld_s2;
	assign level    = lvl_s2;

endmodule

>>> design/bell_curve_light_level.sv
// ----------------------------------------------------------------------------
// bell_curve_light_level
// LED drive level on a Gaussian day curve from the time of day.
// ----------------------------------------------------------------------------
// The req channel takes hour, minute and second; each transfer gives exactly
// one transfer on the rsp channel carrying light_level, in order.
// The window, peak and edge percent are set through the write port (cfg_we,
// cfg_index, cfg_data) while no item is in flight; the user must keep to
// this, as the block does not enforce it. A req item passes three front
// stages (seconds sum, window tests and log lookup, squaring), one stage
// per quotient bit of the 17-bit divider, the exponent product, one stage
// per root-table multiply, the integer shift and two scaling stages.
// Throughput is one item per cycle; every stage holds a valid bit, so the
// pipeline keeps accepting while bubbles remain ahead of a stalled result.
// When rsp is stalled, stages fill up and req.ready drops only once the
// pipeline is full; nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with start 0, end 0,
// peak 0 and edge 1, so the level reads 0 until configured.
// ----------------------------------------------------------------------------
module bell_curve_light_level (
	input  logic        clk,
	input  logic        arst_n,
	bclv_in_if.sink     req,
	bclv_out_if.source  rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	logic [bclv_pkg::XW-1:0] start_q;
	logic [bclv_pkg::XW-1:0] end_q;
	logic [bclv_pkg::PW-1:0] peak_q;
	logic [bclv_pkg::PW-1:0] edge_q;

	logic                      v_s1;
	logic                      v_s2;
	logic                      v_s3;
	logic                      en1;
	logic                      en2;
	logic                      en3;
	logic [bclv_pkg::XW-1:0]   x_s1;
	logic [bclv_pkg::TW-1:0]   t_s2;
	logic [bclv_pkg::XW-1:0]   d_s2;
	bclv_pkg::meta_t           meta_s2;
	logic [bclv_pkg::NW-1:0]   num_s3;
	logic [bclv_pkg::DENW-1:0] den_s3;
	bclv_pkg::meta_t           meta_s3;

	logic [bclv_pkg::XW-1:0]   x_nx;
	logic [bclv_pkg::XW:0]     two_x;
	logic [bclv_pkg::XW:0]     ends_sum;
	logic [bclv_pkg::XW:0]     t_full;
	bclv_pkg::meta_t           meta_nx;
	logic [33:0]               t_sq;

	logic                      div_ready;
	logic                      div_valid;
	logic [bclv_pkg::QW-1:0]   div_quot;
	bclv_pkg::meta_t           div_meta;
	logic                      exp_ready;
	logic                      exp_valid;
	logic [bclv_pkg::RW-1:0]   exp_pow;
	logic                      scl_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			peak_q  <= '0;
			edge_q  <= 7'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				bclv_pkg::REG_START: start_q <= cfg_data;
				bclv_pkg::REG_END:   end_q   <= cfg_data;
				bclv_pkg::REG_PEAK:  peak_q  <= cfg_data[6:0];
				bclv_pkg::REG_EDGE:  edge_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign en3 = !v_s3 || div_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	assign x_nx = bclv_pkg::XW'(req.hour) * 17'd3600 + bclv_pkg::XW'(req.minute) * 17'd60
		+ bclv_pkg::XW'(req.second);

	assign two_x    = {x_s1, 1'b0};
	assign ends_sum = {1'b0, start_q} + {1'b0, end_q};
	assign t_full   = (two_x >= ends_sum) ? two_x - ends_sum : ends_sum - two_x;

	always_comb begin
		meta_nx.lgr  = bclv_pkg::LOG2_TAB[peak_q] - bclv_pkg::LOG2_TAB[edge_q];
		if (start_q >= end_q || peak_q == '0 || x_s1 < start_q || x_s1 > end_q) begin
			meta_nx.mode = bclv_pkg::MODE_ZERO;
		end else if (edge_q >= peak_q) begin
			meta_nx.mode = bclv_pkg::MODE_FLAT;
		end else if (edge_q == '0) begin
			// The edge-to-zero limit keeps only the exact midpoint.
			meta_nx.mode = (t_full == '0) ? bclv_pkg::MODE_FLAT : bclv_pkg::MODE_ZERO;
		end else begin
			meta_nx.mode = bclv_pkg::MODE_CURVE;
		end
	end

	assign t_sq = 34'(t_s2) * 34'(t_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= req.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1 <= x_nx;
		end
		if (en2) begin
			t_s2    <= t_full[bclv_pkg::TW-1:0];
			d_s2    <= end_q - start_q;
			meta_s2 <= meta_nx;
		end
		if (en3) begin
			num_s3  <= {1'b0, t_sq, 16'b0};
			den_s3  <= bclv_pkg::DENW'(d_s2) * bclv_pkg::DENW'(d_s2);
			meta_s3 <= meta_s2;
		end
	end

	bclv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s3),
		.up_ready (div_ready),
		.num      (num_s3),
		.den      (den_s3),
		.up_meta  (meta_s3),
		.dn_valid (div_valid),
		.dn_ready (exp_ready),
		.quot     (div_quot),
		.dn_meta  (div_meta)
	);

	bclv_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_valid),
		.up_ready (exp_ready),
		.u2       (div_quot),
		.up_meta  (div_meta),
		.dn_valid (exp_valid),
		.dn_ready (scl_ready),
		.pow      (exp_pow)
	);

	bclv_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (exp_valid),
		.up_ready (scl_ready),
		.pow      (exp_pow),
		.peak     (peak_q),
		.dn_valid (rsp.valid),
		.dn_ready (rsp.ready),
		.level    (rsp.light_level)
	);

endmodule
